// ----- design/sipq_pkg.sv -----
// Shared types and constants for the sorted-insert priority queue.
`timescale 1ns / 1ps
package sipq_pkg;

  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int COUNT_OUT_W   = 5;
  localparam int DEFAULT_DEPTH = 16;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // broadcast to every cell each cycle
  typedef struct packed {
    logic               insert;
    logic               pop;
    logic [VALUE_W-1:0] value;
  } ctl_t;

  // per-cell position relative to the entry count
  typedef struct packed {
    logic occupied;
    logic at_tail;
  } cell_stat_t;

endpackage

// ----- design/sipq_if.sv -----
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface sipq_in_if;
  import sipq_pkg::*;
  logic               valid;
  logic               ready;
  logic               command;
  logic [VALUE_W-1:0] value;
  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface sipq_out_if;
  import sipq_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [VALUE_W-1:0]     popped_value;
  logic [STATUS_W-1:0]    status;
  logic [COUNT_OUT_W-1:0] entry_count;
  modport source (output valid, output popped_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input entry_count,
                  output ready);
endinterface

// ----- design/sipq_cell.sv -----
// One storage cell of the sorted shift-register queue.
`timescale 1ns / 1ps
module sipq_cell (
  input  logic                         clk,
  input  sipq_pkg::ctl_t               ctl,
  input  sipq_pkg::cell_stat_t         stat,
  input  logic                         left_gt,
  input  logic [sipq_pkg::VALUE_W-1:0] left_entry,
  input  logic [sipq_pkg::VALUE_W-1:0] right_entry,
  output logic                         gt,
  output logic [sipq_pkg::VALUE_W-1:0] entry
);
  import sipq_pkg::*;

  logic [VALUE_W-1:0] entry_r;
  logic [VALUE_W-1:0] entry_nxt;

  assign gt    = stat.occupied && ($signed(entry_r) > $signed(ctl.value));
  assign entry = entry_r;

  // insert: cells holding larger values shift right; the first such cell
  // (or the tail cell) takes the new value
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.pop) begin
      entry_nxt = right_entry;
    end else if (ctl.insert) begin
      if (left_gt) begin
        entry_nxt = left_entry;
      end else if (gt || stat.at_tail) begin
        entry_nxt = ctl.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- design/sorted_insert_priority_queue.sv -----
// Each accepted request's result is registered into the result register and shown on out_ch.
// Throughput: one request per cycle while results are taken; all cells compare
// with the new value in parallel and shift at once; the result register frees when taken.
// Reset (synchronous, rst_n low): entry count and result valid clear; cell contents
// are left as they are and only read once written.
`timescale 1ns / 1ps
module sorted_insert_priority_queue #(
  parameter int DEPTH = sipq_pkg::DEFAULT_DEPTH
) (
  input logic          clk,
  input logic          rst_n,
  sipq_in_if.sink      in_ch,
  sipq_out_if.source   out_ch
);
  import sipq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   out_valid_r;
  logic [VALUE_W-1:0]     popped_r, popped_nxt;
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic [COUNT_OUT_W-1:0] ocount_r;

  logic               accept;
  logic               full;
  logic               empty;
  ctl_t               ctl;
  logic [VALUE_W-1:0] entries [DEPTH];
  logic               gts     [DEPTH];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(DEPTH));
  assign empty       = (count_r == '0);

  assign ctl.insert = accept && (in_ch.command == CMD_INSERT) && !full;
  assign ctl.pop    = accept && (in_ch.command == CMD_POP) && !empty;
  assign ctl.value  = in_ch.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    cell_stat_t         stat;
    logic               left_gt;
    logic [VALUE_W-1:0] left_entry;
    logic [VALUE_W-1:0] right_entry;

    assign stat.occupied = IDX < count_r;
    assign stat.at_tail  = IDX == count_r;

    if (i == 0) begin : g_first
      assign left_gt    = 1'b0;
      assign left_entry = '0;
    end else begin : g_mid
      assign left_gt    = gts[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    sipq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .stat        (stat),
      .left_gt     (left_gt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .gt          (gts[i]),
      .entry       (entries[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    popped_nxt = '0;
    status_nxt = ST_OK;
    if (in_ch.command == CMD_INSERT) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        popped_nxt = entries[0];
        count_nxt  = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
      ocount_r <= COUNT_OUT_W'({{COUNT_OUT_W{1'b0}}, count_nxt});
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = popped_r;
  assign out_ch.status       = status_r;
  assign out_ch.entry_count  = ocount_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.insert |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow count");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> !($signed(entries[0]) > $signed(entries[1])))
    else $error("head entries out of order");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.command == CMD_POP) && empty) |=>
      (out_valid_r && status_r == ST_EMPTY && popped_r == '0))
    else $error("pop on empty not flagged");

endmodule
